// ----- hdl/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int Q_W           = 16;
    localparam int MAG_W         = 17;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic [1:0] br;
        logic [2:0] neg;
        logic [2:0] ovf;
        logic       degen;
    } ctl_t;

endpackage

// ----- hdl/rmq_sqrt_cell.sv -----
// One digit step of the pipelined square root: one root bit per beat.
// Depends on rmq_pkg.
module rmq_sqrt_cell #(
    parameter int RTW = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2*RTW-1:0]              rad_in,
    input  logic [RTW+1:0]                rem_in,
    input  logic [RTW-1:0]                root_in,
    input  logic [3*rmq_pkg::MAG_W-1:0]   mag_in,
    input  rmq_pkg::ctl_t                 ctl_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*RTW-1:0]              rad_out,
    output logic [RTW+1:0]                rem_out,
    output logic [RTW-1:0]                root_out,
    output logic [3*rmq_pkg::MAG_W-1:0]   mag_out,
    output rmq_pkg::ctl_t                 ctl_out
);

    logic                          valid_reg;
    logic [2*RTW-1:0]              rad_reg;
    logic [RTW+1:0]                rem_reg;
    logic [RTW-1:0]                root_reg;
    logic [3*rmq_pkg::MAG_W-1:0]   mag_reg;
    rmq_pkg::ctl_t                 ctl_reg;

    logic [RTW+3:0]       cur;
    logic [RTW+3:0]       trial;
    logic                 take;
    logic [RTW+1:0]       rem_next;
    logic [RTW-1:0]       root_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        cur       = {rem_in, rad_in[2*RTW-1 -: 2]};
        trial     = (RTW+4)'({root_in, 2'b01});
        take      = (cur >= trial);
        rem_next  = take ? (RTW+2)'(cur - trial) : (RTW+2)'(cur);
        root_next = {root_in[RTW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rad_reg  <= rad_in << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            mag_reg  <= mag_in;
            ctl_reg  <= ctl_in;
        end
    end

    assign out_valid = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign mag_out   = mag_reg;
    assign ctl_out   = ctl_reg;

endmodule

// ----- hdl/rmq_div_cell.sv -----
// One restoring-division step for all three numerators: quotient bit SHIFT.
// Depends on rmq_pkg.
module rmq_div_cell #(
    parameter int SHIFT = 15,
    parameter int CW    = 40,
    parameter int DW    = 18
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3*CW-1:0]      num_in,
    input  logic [47:0]          quo_in,
    input  logic [DW-1:0]        den_in,
    input  logic [15:0]          half_in,
    input  rmq_pkg::ctl_t        ctl_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3*CW-1:0]      num_out,
    output logic [47:0]          quo_out,
    output logic [DW-1:0]        den_out,
    output logic [15:0]          half_out,
    output rmq_pkg::ctl_t        ctl_out
);

    logic                 valid_reg;
    logic [3*CW-1:0]      num_reg;
    logic [47:0]          quo_reg;
    logic [DW-1:0]        den_reg;
    logic [15:0]          half_reg;
    rmq_pkg::ctl_t        ctl_reg;

    logic [CW-1:0]        dsh;
    logic [3*CW-1:0]      num_next;
    logic [47:0]          quo_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dsh      = CW'(den_in) << SHIFT;
        num_next = num_in;
        quo_next = quo_in;
        for (int k = 0; k < 3; k++)
        begin
            if (num_in[k*CW +: CW] >= dsh)
            begin
                num_next[k*CW +: CW] = num_in[k*CW +: CW] - dsh;
                quo_next[k*16 + SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            num_reg  <= num_next;
            quo_reg  <= quo_next;
            den_reg  <= den_in;
            half_reg <= half_in;
            ctl_reg  <= ctl_in;
        end
    end

    assign out_valid = valid_reg;
    assign num_out   = num_reg;
    assign quo_out   = quo_reg;
    assign den_out   = den_reg;
    assign half_out  = half_reg;
    assign ctl_out   = ctl_reg;

endmodule

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// Stages: one front stage, one square-root cell per root bit, a divisor setup stage,
// sixteen division cells, one output register.
// Throughput: one matrix per cycle while out_stall is low; each cell holds one beat and
// passes it on when the next stage is ready, and empty cells fill even while the output is stalled.
// Reset: rst_n clears every valid bit asynchronously; payload registers are not reset.
// Depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic signed [15:0] qw,
    output logic [1:0]         branch_taken,
    output logic               degenerate
);

    // Radicand width, root width and division widths all follow FRAC_BITS.
    localparam int RW   = ((FRAC_BITS > 16) ? FRAC_BITS : 17) + 2;
    localparam int NW   = RW + FRAC_BITS;
    localparam int RTW  = (NW + 1) / 2;
    localparam int NUMW = 17 + FRAC_BITS;
    localparam int DW   = RTW + 1;
    localparam int CW   = (NUMW > DW + 16) ? NUMW : DW + 16;
    localparam int MW   = rmq_pkg::MAG_W;

    // ---------------------------------------------------------------
    // Front stage: trace, branch choice, clamped radicand, signed sums.
    // ---------------------------------------------------------------
    logic signed [RW-1:0] e00, e11, e22, tr, rad;
    logic signed [RW-1:0] one_s;
    logic [1:0]           br;
    logic signed [16:0]   dv [3];
    logic [3*MW-1:0]      mag;
    logic [2:0]           neg;
    logic [2*RTW-1:0]     rad_sh;

    always_comb
    begin
        e00   = RW'(m00);
        e11   = RW'(m11);
        e22   = RW'(m22);
        one_s = RW'(1) <<< FRAC_BITS;
        tr    = e00 + e11 + e22;
        if (tr > 0)
        begin
            br  = rmq_pkg::BR_TRACE;
            rad = tr + one_s;
            dv[0] = 17'(m21) - 17'(m12);
            dv[1] = 17'(m02) - 17'(m20);
            dv[2] = 17'(m10) - 17'(m01);
        end
        else if (e00 > e11 && e00 > e22)
        begin
            br  = rmq_pkg::BR_X;
            rad = one_s + e00 - e11 - e22;
            dv[0] = 17'(m21) - 17'(m12);
            dv[1] = 17'(m01) + 17'(m10);
            dv[2] = 17'(m02) + 17'(m20);
        end
        else if (e11 > e22)
        begin
            br  = rmq_pkg::BR_Y;
            rad = one_s + e11 - e00 - e22;
            dv[0] = 17'(m02) - 17'(m20);
            dv[1] = 17'(m01) + 17'(m10);
            dv[2] = 17'(m12) + 17'(m21);
        end
        else
        begin
            br  = rmq_pkg::BR_Z;
            rad = one_s + e22 - e00 - e11;
            dv[0] = 17'(m10) - 17'(m01);
            dv[1] = 17'(m02) + 17'(m20);
            dv[2] = 17'(m12) + 17'(m21);
        end
        // Clamp a negative radicand to zero, then scale by 2^FRAC_BITS.
        if (rad < 0)
            rad = '0;
        rad_sh = (2*RTW)'({rad, {FRAC_BITS{1'b0}}});
        // Magnitudes keep all 17 bits: a sum of two most-negative entries is 2^16.
        for (int k = 0; k < 3; k++)
        begin
            neg[k]          = dv[k][16];
            mag[k*MW +: MW] = dv[k][16] ? 17'(-dv[k]) : 17'(dv[k]);
        end
    end

    logic              s0_valid_reg;
    logic [2*RTW-1:0]  s0_rad_reg;
    logic [3*MW-1:0]   s0_mag_reg;
    rmq_pkg::ctl_t     s0_ctl_reg;
    logic              s0_ready;

    // Square-root chain wiring: index 0 is the front stage output.
    logic              sq_valid [RTW+1];
    logic              sq_ready [RTW+1];
    logic [2*RTW-1:0]  sq_rad   [RTW+1];
    logic [RTW+1:0]    sq_rem   [RTW+1];
    logic [RTW-1:0]    sq_root  [RTW+1];
    logic [3*MW-1:0]   sq_mag   [RTW+1];
    rmq_pkg::ctl_t     sq_ctl   [RTW+1];

    assign s0_ready = !s0_valid_reg || sq_ready[0];
    assign in_stall = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_ready)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_rad_reg <= rad_sh;
            s0_mag_reg <= mag;
            s0_ctl_reg <= '{br: br, neg: neg, ovf: 3'b000, degen: 1'b0};
        end
    end

    assign sq_valid[0] = s0_valid_reg;
    assign sq_rad[0]   = s0_rad_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_mag[0]   = s0_mag_reg;
    assign sq_ctl[0]   = s0_ctl_reg;

    // ---------------------------------------------------------------
    // Square root: one cell per root bit, most significant first.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < RTW; g++)
    begin : g_sqrt
        rmq_sqrt_cell #(.RTW(RTW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_ready  (sq_ready[g]),
            .rad_in    (sq_rad[g]),
            .rem_in    (sq_rem[g]),
            .root_in   (sq_root[g]),
            .mag_in    (sq_mag[g]),
            .ctl_in    (sq_ctl[g]),
            .out_valid (sq_valid[g+1]),
            .out_ready (sq_ready[g+1]),
            .rad_out   (sq_rad[g+1]),
            .rem_out   (sq_rem[g+1]),
            .root_out  (sq_root[g+1]),
            .mag_out   (sq_mag[g+1]),
            .ctl_out   (sq_ctl[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Divisor setup: numerators with rounding term, overflow screen,
    // the half-root component and the zero-divisor flag.
    // ---------------------------------------------------------------
    logic [RTW-1:0]    rt;
    logic [DW-1:0]     den;
    logic [3*CW-1:0]   num;
    logic [2:0]        ovf;
    logic [RTW:0]      hsum;
    logic [15:0]       half;
    rmq_pkg::ctl_t     pctl;

    always_comb
    begin
        rt   = sq_root[RTW];
        den  = {rt, 1'b0};
        for (int k = 0; k < 3; k++)
        begin
            num[k*CW +: CW] = (CW'(sq_mag[RTW][k*MW +: MW]) << FRAC_BITS) + CW'(rt);
            ovf[k]          = (num[k*CW +: CW] >= (CW'(den) << 16));
        end
        hsum = ((RTW+1)'(rt) + (RTW+1)'(1)) >> 1;
        half = (hsum > (RTW+1)'(32767)) ? 16'sd32767 : 16'(hsum);
        pctl       = sq_ctl[RTW];
        pctl.ovf   = ovf;
        pctl.degen = (rt == '0);
    end

    logic              p_valid_reg;
    logic              p_ready;

    logic              dv_valid [17];
    logic              dv_ready [17];
    logic [3*CW-1:0]   dv_num   [17];
    logic [47:0]       dv_quo   [17];
    logic [DW-1:0]     dv_den   [17];
    logic [15:0]       dv_half  [17];
    rmq_pkg::ctl_t     dv_ctl   [17];

    logic [3*CW-1:0]   p_num_reg;
    logic [DW-1:0]     p_den_reg;
    logic [15:0]       p_half_reg;
    rmq_pkg::ctl_t     p_ctl_reg;

    assign p_ready           = !p_valid_reg || dv_ready[0];
    assign sq_ready[RTW]     = p_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (p_ready)
            p_valid_reg <= sq_valid[RTW];
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && sq_valid[RTW])
        begin
            p_num_reg  <= num;
            p_den_reg  <= den;
            p_half_reg <= half;
            p_ctl_reg  <= pctl;
        end
    end

    assign dv_valid[0] = p_valid_reg;
    assign dv_num[0]   = p_num_reg;
    assign dv_quo[0]   = '0;
    assign dv_den[0]   = p_den_reg;
    assign dv_half[0]  = p_half_reg;
    assign dv_ctl[0]   = p_ctl_reg;

    // ---------------------------------------------------------------
    // Division: sixteen quotient bits, one per cell, all three lanes.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < 16; g++)
    begin : g_div
        rmq_div_cell #(.SHIFT(15 - g), .CW(CW), .DW(DW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .num_in    (dv_num[g]),
            .quo_in    (dv_quo[g]),
            .den_in    (dv_den[g]),
            .half_in   (dv_half[g]),
            .ctl_in    (dv_ctl[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .num_out   (dv_num[g+1]),
            .quo_out   (dv_quo[g+1]),
            .den_out   (dv_den[g+1]),
            .half_out  (dv_half[g+1]),
            .ctl_out   (dv_ctl[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Output: reapply signs, saturate, route components by branch.
    // ---------------------------------------------------------------
    rmq_pkg::ctl_t     fctl;
    logic [15:0]       sv  [3];
    logic [15:0]       qv  [3];
    logic [15:0]       hv;
    logic [15:0]       nx, ny, nz, nw;

    always_comb
    begin
        fctl = dv_ctl[16];
        hv   = dv_half[16];
        for (int k = 0; k < 3; k++)
        begin
            sv[k] = dv_quo[16][k*16 +: 16];
            if (fctl.ovf[k])
                qv[k] = fctl.neg[k] ? 16'h8000 : 16'h7FFF;
            else if (fctl.neg[k])
                qv[k] = (sv[k] > 16'd32768) ? 16'h8000 : 16'(-sv[k]);
            else
                qv[k] = (sv[k] > 16'd32767) ? 16'h7FFF : sv[k];
        end
        unique case (fctl.br)
            rmq_pkg::BR_TRACE: begin nx = qv[0]; ny = qv[1]; nz = qv[2]; nw = hv;    end
            rmq_pkg::BR_X:     begin nx = hv;    ny = qv[1]; nz = qv[2]; nw = qv[0]; end
            rmq_pkg::BR_Y:     begin nx = qv[1]; ny = hv;    nz = qv[2]; nw = qv[0]; end
            default:           begin nx = qv[1]; ny = qv[2]; nz = hv;    nw = qv[0]; end
        endcase
        // Drop everything to zero when the root came out zero.
        if (fctl.degen)
        begin
            nx = '0;
            ny = '0;
            nz = '0;
            nw = '0;
        end
    end

    logic              o_valid_reg;
    logic              o_ready;
    logic [15:0]       qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]        br_reg;
    logic              degen_reg;

    assign o_ready      = !o_valid_reg || !out_stall;
    assign dv_ready[16] = o_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= dv_valid[16];
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && dv_valid[16])
        begin
            qx_reg    <= nx;
            qy_reg    <= ny;
            qz_reg    <= nz;
            qw_reg    <= nw;
            br_reg    <= fctl.br;
            degen_reg <= fctl.degen;
        end
    end

    assign out_valid    = o_valid_reg;
    assign qx           = qx_reg;
    assign qy           = qy_reg;
    assign qz           = qz_reg;
    assign qw           = qw_reg;
    assign branch_taken = br_reg;
    assign degenerate   = degen_reg;

endmodule
